// File: rtl/hbed_pkg.sv
// ----------------------------------------------------------------------------
// hbed_pkg
// Shared types, register codes and fixed-point constants for the hall button
// event detector.
// ----------------------------------------------------------------------------
package hbed_pkg;

   // fixed field widths
   localparam int BTN_W   = 4;
   localparam int SMP_W   = 12;
   localparam int TIME_W  = 32;
   localparam int RATE_W  = 17;
   localparam int THR_W   = 12;
   localparam int LPM_W   = 16;
   localparam int MASK_W  = 16;
   localparam int EN_W    = 5;
   localparam int FRAC_W  = 16;

   // configuration port
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   localparam logic [RATE_W-1:0] ONE_Q16  = 17'h10000;
   localparam logic [RATE_W-1:0] HALF_Q16 = 17'h08000;

   // register index codes (byte address / 4)
   localparam logic [2:0] REG_THRESHOLD     = 3'd0;
   localparam logic [2:0] REG_FILTER_ALPHA  = 3'd1;
   localparam logic [2:0] REG_ADAPT_RATE    = 3'd2;
   localparam logic [2:0] REG_LONG_PRESS_MS = 3'd3;
   localparam logic [2:0] REG_COMBO_MASK    = 3'd4;
   localparam logic [2:0] REG_EVENT_ENABLE  = 3'd5;

   // event_enable bit positions
   localparam int EV_PRESS   = 0;
   localparam int EV_RELEASE = 1;
   localparam int EV_SHORT   = 2;
   localparam int EV_LONG    = 3;
   localparam int EV_COMBO   = 4;

   typedef struct packed {
      logic [THR_W-1:0]  threshold;
      logic [RATE_W-1:0] filter_alpha;
      logic [RATE_W-1:0] adapt_rate;
      logic [LPM_W-1:0]  long_press_ms;
      logic [MASK_W-1:0] combo_mask;
      logic [EN_W-1:0]   event_enable;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul_a;
      logic mul_b;
      logic filt;
      logic mag;
      logic mul_c;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic arith;
      logic out_free;
   } dp_status_type;

   // rates above one act as one
   function automatic logic [RATE_W-1:0] rate_sat(input logic [RATE_W-1:0] r);
      rate_sat = (r > ONE_Q16) ? ONE_Q16 : r;
   endfunction

endpackage

// File: rtl/hbed_csr.sv
// ----------------------------------------------------------------------------
// hbed_csr
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module hbed_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hbed_pkg::CSR_AW-1:0]   paddr,
   input  logic [hbed_pkg::CSR_DW-1:0]   pwdata,
   output logic [hbed_pkg::CSR_DW-1:0]   prdata,
   output hbed_pkg::cfg_type             cfg
);

   hbed_pkg::cfg_type cfg_ff;
   hbed_pkg::cfg_type cfg_in;
   logic [2:0]        reg_sel;
   logic              wr_en;

   assign reg_sel = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            hbed_pkg::REG_THRESHOLD:     cfg_in.threshold     = pwdata[hbed_pkg::THR_W-1:0];
            hbed_pkg::REG_FILTER_ALPHA:  cfg_in.filter_alpha  = pwdata[hbed_pkg::RATE_W-1:0];
            hbed_pkg::REG_ADAPT_RATE:    cfg_in.adapt_rate    = pwdata[hbed_pkg::RATE_W-1:0];
            hbed_pkg::REG_LONG_PRESS_MS: cfg_in.long_press_ms = pwdata[hbed_pkg::LPM_W-1:0];
            hbed_pkg::REG_COMBO_MASK:    cfg_in.combo_mask    = pwdata[hbed_pkg::MASK_W-1:0];
            hbed_pkg::REG_EVENT_ENABLE:  cfg_in.event_enable  = pwdata[hbed_pkg::EN_W-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold     <= 12'd80;
         cfg_ff.filter_alpha  <= 17'd13107;
         cfg_ff.adapt_rate    <= 17'd328;
         cfg_ff.long_press_ms <= 16'd1000;
         cfg_ff.combo_mask    <= 16'd0;
         cfg_ff.event_enable  <= 5'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         hbed_pkg::REG_THRESHOLD:     prdata = 32'(cfg_ff.threshold);
         hbed_pkg::REG_FILTER_ALPHA:  prdata = 32'(cfg_ff.filter_alpha);
         hbed_pkg::REG_ADAPT_RATE:    prdata = 32'(cfg_ff.adapt_rate);
         hbed_pkg::REG_LONG_PRESS_MS: prdata = 32'(cfg_ff.long_press_ms);
         hbed_pkg::REG_COMBO_MASK:    prdata = 32'(cfg_ff.combo_mask);
         hbed_pkg::REG_EVENT_ENABLE:  prdata = 32'(cfg_ff.event_enable);
         default:                     prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/hbed_ctrl.sv
// ----------------------------------------------------------------------------
// hbed_ctrl
// Sequencer: steps one item through the shared multiplier and the compare
// if it needs arithmetic, then commits the per-button state and the result.
// ----------------------------------------------------------------------------
module hbed_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hbed_pkg::dp_status_type status,
   output hbed_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL_A = 3'd1;
   localparam logic [2:0] ST_MUL_B = 3'd2;
   localparam logic [2:0] ST_FILT  = 3'd3;
   localparam logic [2:0] ST_MAG   = 3'd4;
   localparam logic [2:0] ST_MUL_C = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               // calibrate and out-of-range items need no arithmetic
               state_in = status.arith ? ST_MUL_A : ST_DONE;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_FILT;
         end
         ST_FILT: begin
            cmd.filt = 1'b1;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            cmd.mul_c = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/hbed_dp.sv
// ----------------------------------------------------------------------------
// hbed_dp
// Datapath: per-button level state, one shared 17 x level multiplier,
// press/release logic, scan bookkeeping and the result register.
// ----------------------------------------------------------------------------
module hbed_dp #(
   parameter int BUTTONS     = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hbed_pkg::ctrl_cmd_type        cmd,
   output hbed_pkg::dp_status_type       status,
   input  hbed_pkg::cfg_type             cfg,
   input  logic                          req_mode,
   input  logic [hbed_pkg::BTN_W-1:0]    req_button,
   input  logic [hbed_pkg::SMP_W-1:0]    req_sample,
   input  logic [hbed_pkg::TIME_W-1:0]   req_time_ms,
   input  logic                          req_last_of_scan,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hbed_pkg::BTN_W-1:0]    rsp_which_button,
   output logic                          rsp_held,
   output logic                          rsp_press_event,
   output logic                          rsp_release_event,
   output logic                          rsp_short_event,
   output logic                          rsp_long_event,
   output logic                          rsp_combo_event,
   output logic [hbed_pkg::MASK_W-1:0]   rsp_scan_pressed
);

   localparam int LW    = SAMPLE_BITS + hbed_pkg::FRAC_W;     // level width
   localparam int PW    = LW + hbed_pkg::RATE_W;              // product width
   localparam int PAW   = SAMPLE_BITS + hbed_pkg::RATE_W;     // alpha * sample
   localparam int CW    = (LW > 28) ? LW : 28;                // compare width
   localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
   localparam logic [hbed_pkg::BTN_W:0] BTN_LIMIT = (hbed_pkg::BTN_W + 1)'(BUTTONS);

   // latched item
   logic                          mode_ff;
   logic [hbed_pkg::BTN_W-1:0]    btn_ff;
   logic [SAMPLE_BITS-1:0]        smp_ff;
   logic [hbed_pkg::TIME_W-1:0]   time_ff;
   logic                          last_ff;
   logic                          in_range_ff;

   // per-button state
   logic [LW-1:0]                 filt_ff  [BUTTONS];
   logic [LW-1:0]                 base_ff  [BUTTONS];
   logic [hbed_pkg::TIME_W-1:0]   pt_ff    [BUTTONS];
   logic [BUTTONS-1:0]            pressed_ff;
   logic [BUTTONS-1:0]            lf_ff;
   logic [hbed_pkg::MASK_W-1:0]   acc_ff;
   logic [hbed_pkg::MASK_W-1:0]   acc_in;

   // arithmetic pipeline registers
   logic [PAW-1:0]                prod_a_ff;
   logic [PW-1:0]                 prod_ff;
   logic [LW-1:0]                 f_new_ff;
   logic [LW-1:0]                 mag_ff;
   logic [LW-1:0]                 base_cur_ff;
   logic                          up_ff;
   logic                          above_ff;
   logic [hbed_pkg::TIME_W-1:0]   dur_ff;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [hbed_pkg::BTN_W-1:0]    rsp_btn_ff;
   logic                          rsp_held_ff;
   logic                          rsp_press_ff;
   logic                          rsp_rel_ff;
   logic                          rsp_short_ff;
   logic                          rsp_long_ff;
   logic                          rsp_combo_ff;
   logic [hbed_pkg::MASK_W-1:0]   rsp_scan_ff;

   logic [IDX_W-1:0]              idx;
   logic [hbed_pkg::RATE_W-1:0]   a_sat;
   logic [hbed_pkg::RATE_W-1:0]   r_sat;
   logic [hbed_pkg::RATE_W-1:0]   mul_x;
   logic [LW-1:0]                 mul_y;
   logic [PW-1:0]                 mul_p;
   logic [PW:0]                   filt_sum;
   logic [PW:0]                   step_rnd;
   logic [LW-1:0]                 step;
   logic [LW-1:0]                 base_sel;
   logic                          up;
   logic [LW-1:0]                 mag;
   logic [LW-1:0]                 xq;

   logic                          is_cal;
   logic                          is_norm;
   logic                          cur_pressed;
   logic                          cur_lf;
   logic                          pressed_in;
   logic                          lf_in;
   logic                          pt_wr;
   logic [LW-1:0]                 base_in;
   logic                          ev_press;
   logic                          ev_rel;
   logic                          ev_short;
   logic                          ev_long;
   logic                          held;
   logic [hbed_pkg::MASK_W-1:0]   scan;
   logic                          combo;

   assign idx   = btn_ff[IDX_W-1:0];
   assign a_sat = hbed_pkg::rate_sat(cfg.filter_alpha);
   assign r_sat = hbed_pkg::rate_sat(cfg.adapt_rate);
   assign xq    = {smp_ff, {hbed_pkg::FRAC_W{1'b0}}};

   assign status.arith    = req_mode & ({1'b0, req_button} < BTN_LIMIT);
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;

   // shared multiplier: alpha*sample, (1-alpha)*level, rate*distance
   always_comb begin
      priority if (cmd.mul_a) begin
         mul_x = a_sat;
         mul_y = LW'(smp_ff);
      end else if (cmd.mul_b) begin
         mul_x = hbed_pkg::ONE_Q16 - a_sat;
         mul_y = filt_ff[idx];
      end else begin
         mul_x = r_sat;
         mul_y = mag_ff;
      end
   end

   assign mul_p = PW'(mul_x) * PW'(mul_y);

   assign filt_sum = (PW + 1)'({prod_a_ff, {hbed_pkg::FRAC_W{1'b0}}})
                   + (PW + 1)'(prod_ff) + (PW + 1)'(hbed_pkg::HALF_Q16);

   assign step_rnd = (PW + 1)'(prod_ff) + (PW + 1)'(hbed_pkg::HALF_Q16);
   assign step     = step_rnd[LW+hbed_pkg::FRAC_W-1:hbed_pkg::FRAC_W];

   assign base_sel = base_ff[idx];
   assign up       = (f_new_ff >= base_sel);
   assign mag      = up ? (f_new_ff - base_sel) : (base_sel - f_new_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff     <= req_mode;
         btn_ff      <= req_button;
         smp_ff      <= SAMPLE_BITS'(req_sample);
         time_ff     <= req_time_ms;
         last_ff     <= req_last_of_scan;
         in_range_ff <= ({1'b0, req_button} < BTN_LIMIT);
      end
      if (cmd.mul_a) begin
         prod_a_ff <= mul_p[PAW-1:0];
      end
      if (cmd.mul_b || cmd.mul_c) begin
         prod_ff <= mul_p;
      end
      if (cmd.filt) begin
         f_new_ff <= filt_sum[LW+hbed_pkg::FRAC_W-1:hbed_pkg::FRAC_W];
      end
      if (cmd.mag) begin
         up_ff       <= up;
         mag_ff      <= mag;
         base_cur_ff <= base_sel;
         above_ff    <= CW'(mag) > CW'({cfg.threshold, {hbed_pkg::FRAC_W{1'b0}}});
         dur_ff      <= time_ff - pt_ff[idx];
      end
   end

   // press / release / hold decisions for a normal sample, plus scan and combo
   always_comb begin
      is_cal      = in_range_ff & ~mode_ff;
      is_norm     = in_range_ff & mode_ff;
      cur_pressed = pressed_ff[idx];
      cur_lf      = lf_ff[idx];
      pressed_in  = cur_pressed;
      lf_in       = cur_lf;
      pt_wr       = 1'b0;
      base_in     = base_cur_ff;
      ev_press    = 1'b0;
      ev_rel      = 1'b0;
      ev_short    = 1'b0;
      ev_long     = 1'b0;
      if (above_ff) begin
         if (!cur_pressed) begin
            pressed_in = 1'b1;
            pt_wr      = 1'b1;
            lf_in      = 1'b0;
            ev_press   = cfg.event_enable[hbed_pkg::EV_PRESS];
         end else if (!cur_lf && (dur_ff >= 32'(cfg.long_press_ms))) begin
            // flag set even with long events disabled, to block the short event
            lf_in   = 1'b1;
            ev_long = cfg.event_enable[hbed_pkg::EV_LONG];
         end
      end else begin
         if (cur_pressed) begin
            pressed_in = 1'b0;
            ev_rel     = cfg.event_enable[hbed_pkg::EV_RELEASE];
            if (!cur_lf && (dur_ff < 32'(cfg.long_press_ms))) begin
               ev_short = cfg.event_enable[hbed_pkg::EV_SHORT];
            end
            lf_in = 1'b0;
         end
         base_in = up_ff ? (base_cur_ff + step) : (base_cur_ff - step);
      end
      held   = is_norm & pressed_in;
      scan   = acc_ff | (held ? (hbed_pkg::MASK_W'(1) << btn_ff) : '0);
      combo  = last_ff & ~is_cal & ((scan & cfg.combo_mask) == cfg.combo_mask)
             & cfg.event_enable[hbed_pkg::EV_COMBO];
      acc_in = last_ff ? '0 : scan;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            filt_ff[i] <= '0;
            base_ff[i] <= '0;
            pt_ff[i]   <= '0;
         end
         pressed_ff <= '0;
         lf_ff      <= '0;
         acc_ff     <= '0;
      end else if (cmd.commit) begin
         acc_ff <= acc_in;
         if (is_cal) begin
            filt_ff[idx]    <= xq;
            base_ff[idx]    <= xq;
            pressed_ff[idx] <= 1'b0;
            lf_ff[idx]      <= 1'b0;
         end else if (is_norm) begin
            filt_ff[idx]    <= f_new_ff;
            base_ff[idx]    <= base_in;
            pressed_ff[idx] <= pressed_in;
            lf_ff[idx]      <= lf_in;
            if (pt_wr) begin
               pt_ff[idx] <= time_ff;
            end
         end
      end
   end

   // result register; frees up in the cycle the consumer takes the item
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_btn_ff   <= btn_ff;
         rsp_held_ff  <= held;
         rsp_press_ff <= is_norm & ev_press;
         rsp_rel_ff   <= is_norm & ev_rel;
         rsp_short_ff <= is_norm & ev_short;
         rsp_long_ff  <= is_norm & ev_long;
         rsp_combo_ff <= combo;
         rsp_scan_ff  <= scan;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_which_button  = rsp_btn_ff;
   assign rsp_held          = rsp_held_ff;
   assign rsp_press_event   = rsp_press_ff;
   assign rsp_release_event = rsp_rel_ff;
   assign rsp_short_event   = rsp_short_ff;
   assign rsp_long_event    = rsp_long_ff;
   assign rsp_combo_event   = rsp_combo_ff;
   assign rsp_scan_pressed  = rsp_scan_ff;

endmodule

// File: rtl/hall_button_event_detector.sv
// ----------------------------------------------------------------------------
// hall_button_event_detector
// Smooths hall-sensor samples per button, tracks a baseline while released
// and reports press, release, short, long and combination events.
// ----------------------------------------------------------------------------
//   port group   direction   handshake            carries
//   req_*        in          req_valid/req_stall   one sample of one button
//   rsp_*        out         rsp_valid/rsp_stall   one result per sample
//   csr_*        in/out      psel/penable/pready   six config registers
//
// A normal sample goes from accept to the next accept through three
// passes through the single shared multiplier, the filter add, the baseline
// compare, the commit and the idle state that takes the next item.
// Calibrate and out-of-range samples go straight to the commit, then idle.
// req_stall is high while an item is in flight; the result waits in an output
// register, and the commit holds only while that register is full and stalled.
// Synchronous reset clears all button state, the scan mask and result valid.
// ----------------------------------------------------------------------------
module hall_button_event_detector #(
   parameter int BUTTONS     = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [hbed_pkg::BTN_W-1:0]    req_button,
   input  logic [hbed_pkg::SMP_W-1:0]    req_sample,
   input  logic [hbed_pkg::TIME_W-1:0]   req_time_ms,
   input  logic                          req_last_of_scan,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hbed_pkg::BTN_W-1:0]    rsp_which_button,
   output logic                          rsp_held,
   output logic                          rsp_press_event,
   output logic                          rsp_release_event,
   output logic                          rsp_short_event,
   output logic                          rsp_long_event,
   output logic                          rsp_combo_event,
   output logic [hbed_pkg::MASK_W-1:0]   rsp_scan_pressed,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hbed_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hbed_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hbed_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   hbed_pkg::cfg_type       cfg;
   hbed_pkg::ctrl_cmd_type  cmd;
   hbed_pkg::dp_status_type status;

   assign csr_pready = 1'b1;

   hbed_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   hbed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hbed_dp #(
      .BUTTONS     (BUTTONS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg),
      .req_mode          (req_mode),
      .req_button        (req_button),
      .req_sample        (req_sample),
      .req_time_ms       (req_time_ms),
      .req_last_of_scan  (req_last_of_scan),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_which_button  (rsp_which_button),
      .rsp_held          (rsp_held),
      .rsp_press_event   (rsp_press_event),
      .rsp_release_event (rsp_release_event),
      .rsp_short_event   (rsp_short_event),
      .rsp_long_event    (rsp_long_event),
      .rsp_combo_event   (rsp_combo_event),
      .rsp_scan_pressed  (rsp_scan_pressed)
   );

endmodule

// File: bench/tb_hall_button_event_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hall_button_event_detector
// Self-checking bench for the hall button event detector. A short directed
// run walks press, release, short, long and combination events, wrapping
// time stamps and saturated rates. Randomized scans then run under several
// handshake pacing mixes and a long output hold-off. Each result is checked
// against a cycle-free model of the detector kept inside the bench.
// ----------------------------------------------------------------------------
module tb_hall_button_event_detector;

   localparam int NUM_BUTTONS    = 16;
   localparam int LVL_W          = hbed_pkg::SMP_W + hbed_pkg::FRAC_W;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 16;
   localparam int MAX_REPORTED   = 10;

   localparam logic MODE_CAL    = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef struct packed {
      logic                          mode;
      logic [hbed_pkg::BTN_W-1:0]    button;
      logic [hbed_pkg::SMP_W-1:0]    level;
      logic [hbed_pkg::TIME_W-1:0]   time_ms;
      logic                          last;
   } hall_sample_type;

   typedef struct packed {
      logic [hbed_pkg::BTN_W-1:0]    which_button;
      logic                          held;
      logic                          press_ev;
      logic                          rel_ev;
      logic                          short_ev;
      logic                          long_ev;
      logic                          combo_ev;
      logic [hbed_pkg::MASK_W-1:0]   scan_pressed;
   } button_report_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_mode = MODE_SAMPLE;
   logic [hbed_pkg::BTN_W-1:0]    req_button = '0;
   logic [hbed_pkg::SMP_W-1:0]    req_sample = '0;
   logic [hbed_pkg::TIME_W-1:0]   req_time_ms = '0;
   logic                          req_last_of_scan = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [hbed_pkg::BTN_W-1:0]    rsp_which_button;
   logic                          rsp_held;
   logic                          rsp_press_event;
   logic                          rsp_release_event;
   logic                          rsp_short_event;
   logic                          rsp_long_event;
   logic                          rsp_combo_event;
   logic [hbed_pkg::MASK_W-1:0]   rsp_scan_pressed;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [hbed_pkg::CSR_AW-1:0]   csr_paddr = '0;
   logic [hbed_pkg::CSR_DW-1:0]   csr_pwdata = '0;
   logic [hbed_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   hall_button_event_detector i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_button        (req_button),
      .req_sample        (req_sample),
      .req_time_ms       (req_time_ms),
      .req_last_of_scan  (req_last_of_scan),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_which_button  (rsp_which_button),
      .rsp_held          (rsp_held),
      .rsp_press_event   (rsp_press_event),
      .rsp_release_event (rsp_release_event),
      .rsp_short_event   (rsp_short_event),
      .rsp_long_event    (rsp_long_event),
      .rsp_combo_event   (rsp_combo_event),
      .rsp_scan_pressed  (rsp_scan_pressed),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // detector model state
   hbed_pkg::cfg_type             cfg;
   logic [LVL_W-1:0]              smooth_q   [NUM_BUTTONS];
   logic [LVL_W-1:0]              base_q     [NUM_BUTTONS];
   logic                          is_held    [NUM_BUTTONS];
   logic [hbed_pkg::TIME_W-1:0]   held_since [NUM_BUTTONS];
   logic                          long_done  [NUM_BUTTONS];
   logic [hbed_pkg::MASK_W-1:0]   scan_bits;
   button_report_type             pending_reports [$];

   // stimulus shaping state
   logic [hbed_pkg::SMP_W-1:0]    rest_lvl  [NUM_BUTTONS];
   logic                          want_held [NUM_BUTTONS];
   logic                          push_down [NUM_BUTTONS];
   logic [hbed_pkg::TIME_W-1:0]   now_ms = 32'hFFFF_FF00;

   int          gap_pct = 0;
   int          stall_pct = 0;
   int          bad_reports = 0;
   int unsigned cycle_count = 0;
   logic        holdoff_go = 1'b0;
   logic        holdoff_ack = 1'b0;
   int          holdoff_left = 0;

   function automatic void clear_detector_state();
      cfg.threshold     = 12'd80;
      cfg.filter_alpha  = 17'd13107;
      cfg.adapt_rate    = 17'd328;
      cfg.long_press_ms = 16'd1000;
      cfg.combo_mask    = '0;
      cfg.event_enable  = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         smooth_q[i]   = '0;
         base_q[i]     = '0;
         is_held[i]    = 1'b0;
         held_since[i] = '0;
         long_done[i]  = 1'b0;
         rest_lvl[i]   = 12'd2048;
         want_held[i]  = 1'b0;
         push_down[i]  = 1'b0;
      end
      scan_bits = '0;
   endfunction

   function automatic button_report_type detect_events(input hall_sample_type s);
      button_report_type r;
      logic [63:0]       a, k, xq, f, base, mag, stp;
      logic              up;
      logic [31:0]       held_for;
      int                b;
      r = '0;
      b = int'(s.button);
      r.which_button = s.button;
      if (s.mode == MODE_CAL) begin
         smooth_q[b]  = {s.level, 16'd0};
         base_q[b]    = {s.level, 16'd0};
         is_held[b]   = 1'b0;
         long_done[b] = 1'b0;
      end else begin
         // rates above one behave as one
         a = (cfg.filter_alpha > hbed_pkg::ONE_Q16) ? 64'(hbed_pkg::ONE_Q16)
                                                    : 64'(cfg.filter_alpha);
         k = (cfg.adapt_rate > hbed_pkg::ONE_Q16) ? 64'(hbed_pkg::ONE_Q16)
                                                  : 64'(cfg.adapt_rate);
         xq = 64'(s.level) << hbed_pkg::FRAC_W;
         f = (a * xq + (64'(hbed_pkg::ONE_Q16) - a) * 64'(smooth_q[b])
              + 64'(hbed_pkg::HALF_Q16)) >> hbed_pkg::FRAC_W;
         smooth_q[b] = f[LVL_W-1:0];
         base = 64'(base_q[b]);
         up = (f >= base);
         mag = up ? f - base : base - f;
         held_for = s.time_ms - held_since[b];
         if (mag > (64'(cfg.threshold) << hbed_pkg::FRAC_W)) begin
            if (!is_held[b]) begin
               is_held[b]    = 1'b1;
               held_since[b] = s.time_ms;
               long_done[b]  = 1'b0;
               r.press_ev    = cfg.event_enable[hbed_pkg::EV_PRESS];
            end else if (!long_done[b] && held_for >= 32'(cfg.long_press_ms)) begin
               // flag is set even when the long event is masked off
               long_done[b] = 1'b1;
               r.long_ev    = cfg.event_enable[hbed_pkg::EV_LONG];
            end
         end else begin
            if (is_held[b]) begin
               is_held[b] = 1'b0;
               r.rel_ev   = cfg.event_enable[hbed_pkg::EV_RELEASE];
               if (!long_done[b] && held_for < 32'(cfg.long_press_ms))
                  r.short_ev = cfg.event_enable[hbed_pkg::EV_SHORT];
               long_done[b] = 1'b0;
            end
            // baseline tracks only while released
            stp = (mag * k + 64'(hbed_pkg::HALF_Q16)) >> hbed_pkg::FRAC_W;
            base_q[b] = up ? LVL_W'(base + stp) : LVL_W'(base - stp);
         end
         r.held = is_held[b];
         if (r.held)
            scan_bits[b] = 1'b1;
      end
      r.scan_pressed = scan_bits;
      if (s.last) begin
         if (s.mode == MODE_SAMPLE && (scan_bits & cfg.combo_mask) == cfg.combo_mask)
            r.combo_ev = cfg.event_enable[hbed_pkg::EV_COMBO];
         scan_bits = '0;
      end
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input button_report_type want,
                                         input button_report_type seen);
      bad_reports++;
      if (bad_reports <= MAX_REPORTED) begin
         $display("%0t: %s", $realtime, what);
         $display("   want btn=%0d held=%b prs=%b rel=%b shrt=%b long=%b cmb=%b scan=%h",
                  want.which_button, want.held, want.press_ev, want.rel_ev,
                  want.short_ev, want.long_ev, want.combo_ev, want.scan_pressed);
         $display("   seen btn=%0d held=%b prs=%b rel=%b shrt=%b long=%b cmb=%b scan=%h",
                  seen.which_button, seen.held, seen.press_ev, seen.rel_ev,
                  seen.short_ev, seen.long_ev, seen.combo_ev, seen.scan_pressed);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      button_report_type seen, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_which_button, rsp_held, rsp_press_event, rsp_release_event,
                 rsp_short_event, rsp_long_event, rsp_combo_event, rsp_scan_pressed};
         if (pending_reports.size() == 0) begin
            note_mismatch("result with no item outstanding", '0, seen);
         end else begin
            want = pending_reports.pop_front();
            if (seen !== want)
               note_mismatch("result mismatch", want, seen);
         end
      end
   end

   // receiver pacing; a hold-off request keeps stall up for a fixed stretch
   always @(posedge clock) begin
      if (holdoff_go != holdoff_ack) begin
         holdoff_ack  <= holdoff_go;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_sample(input hall_sample_type s);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= s.mode;
      req_button       <= s.button;
      req_sample       <= s.level;
      req_time_ms      <= s.time_ms;
      req_last_of_scan <= s.last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_reports.push_back(detect_events(s));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [hbed_pkg::CSR_DW-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      unique case (idx)
         hbed_pkg::REG_THRESHOLD:     cfg.threshold     = val[hbed_pkg::THR_W-1:0];
         hbed_pkg::REG_FILTER_ALPHA:  cfg.filter_alpha  = val[hbed_pkg::RATE_W-1:0];
         hbed_pkg::REG_ADAPT_RATE:    cfg.adapt_rate    = val[hbed_pkg::RATE_W-1:0];
         hbed_pkg::REG_LONG_PRESS_MS: cfg.long_press_ms = val[hbed_pkg::LPM_W-1:0];
         hbed_pkg::REG_COMBO_MASK:    cfg.combo_mask    = val[hbed_pkg::MASK_W-1:0];
         hbed_pkg::REG_EVENT_ENABLE:  cfg.event_enable  = val[hbed_pkg::EN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // mostly plausible press/release traffic, with recalibration and noise mixed in
   function automatic hall_sample_type make_sample(input int b, input logic last);
      hall_sample_type s;
      int              pick, lvl, off;
      logic            dn;
      pick = $urandom_range(99);
      s.mode    = MODE_SAMPLE;
      s.button  = hbed_pkg::BTN_W'(b);
      s.time_ms = now_ms;
      s.last    = last;
      if (pick < 6) begin
         s.mode = MODE_CAL;
         s.level = hbed_pkg::SMP_W'($urandom_range(200, 3900));
         rest_lvl[b]  = s.level;
         want_held[b] = 1'b0;
      end else if (pick < 12) begin
         s.mode    = 1'($urandom_range(1));
         s.level   = hbed_pkg::SMP_W'($urandom);
         s.time_ms = $urandom;
         s.last    = 1'($urandom_range(1));
         if (s.mode == MODE_CAL)
            rest_lvl[b] = s.level;
      end else begin
         if ($urandom_range(7) == 0) begin
            want_held[b] = !want_held[b];
            push_down[b] = 1'($urandom_range(1));
         end
         if (want_held[b]) begin
            off = int'(cfg.threshold) + $urandom_range(30, 900);
            dn  = push_down[b];
         end else begin
            off = $urandom_range(0, cfg.threshold / 3);
            dn  = 1'($urandom_range(1));
         end
         lvl = dn ? int'(rest_lvl[b]) - off : int'(rest_lvl[b]) + off;
         if (lvl < 0)
            lvl = 0;
         if (lvl > 4095)
            lvl = 4095;
         s.level = lvl[hbed_pkg::SMP_W-1:0];
      end
      return s;
   endfunction

   task automatic send_scan(output int count);
      int n, first;
      n = ($urandom_range(9) == 0) ? NUM_BUTTONS : $urandom_range(1, 4);
      first = ($urandom_range(9) < 7) ? 0 : $urandom_range(NUM_BUTTONS - 1);
      now_ms += $urandom_range(1, 30);
      if ($urandom_range(49) == 0)
         now_ms += $urandom;
      for (int i = 0; i < n; i++)
         send_sample(make_sample((first + i) % NUM_BUTTONS, i == n - 1));
      count = n;
   endtask

   task automatic send_scans(input int n_items);
      int sent, k;
      sent = 0;
      while (sent < n_items) begin
         send_scan(k);
         sent += k;
      end
   endtask

   task automatic calibrate_all();
      hall_sample_type s;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         s = '{MODE_CAL, hbed_pkg::BTN_W'(b), hbed_pkg::SMP_W'($urandom_range(300, 3800)),
               now_ms, b == NUM_BUTTONS - 1};
         rest_lvl[b]  = s.level;
         want_held[b] = 1'b0;
         send_sample(s);
      end
   endtask

   task automatic shuffle_config();
      write_reg(hbed_pkg::REG_THRESHOLD,
                ($urandom_range(19) == 0) ? 0 : $urandom_range(20, 500));
      write_reg(hbed_pkg::REG_FILTER_ALPHA,
                ($urandom_range(4) == 0) ? 32'h1FFFF : $urandom_range(6000, 65536));
      write_reg(hbed_pkg::REG_ADAPT_RATE,
                ($urandom_range(9) == 0) ? 65536 : $urandom_range(0, 3000));
      write_reg(hbed_pkg::REG_LONG_PRESS_MS, $urandom_range(0, 300));
      write_reg(hbed_pkg::REG_COMBO_MASK,
                ($urandom_range(9) == 0) ? 32'hFFFF : $urandom_range(0, 15));
      write_reg(hbed_pkg::REG_EVENT_ENABLE,
                ($urandom_range(3) == 0) ? $urandom_range(31) : 31);
   endtask

   // defaults out of reset: events masked, default rates and threshold
   task automatic test_reset_defaults();
      gap_pct   = 0;
      stall_pct = 0;
      send_sample('{MODE_CAL, 4'd5, 12'd1000, 32'd40, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd5, 12'd4095, 32'd50, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd6, 12'd0, 32'd60, 1'b1});
      wait_drained();
   endtask

   task automatic test_directed_cases();
      gap_pct   = 0;
      stall_pct = 0;
      // instant filter, frozen baseline, zero long time, time wraps mid-hold
      write_reg(hbed_pkg::REG_THRESHOLD, 100);
      write_reg(hbed_pkg::REG_FILTER_ALPHA, 32'h1FFFF);
      write_reg(hbed_pkg::REG_ADAPT_RATE, 0);
      write_reg(hbed_pkg::REG_LONG_PRESS_MS, 0);
      write_reg(hbed_pkg::REG_COMBO_MASK, 32'h0003);
      write_reg(hbed_pkg::REG_EVENT_ENABLE, 31);
      send_sample('{MODE_CAL, 4'd0, 12'd2000, 32'hFFFF_FFF0, 1'b0});
      send_sample('{MODE_CAL, 4'd1, 12'd0, 32'hFFFF_FFF0, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd0, 12'd4095, 32'hFFFF_FFF0, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd0, 12'd4095, 32'h0000_0004, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd1, 12'd4095, 32'h0000_0004, 1'b1});
      send_sample('{MODE_SAMPLE, 4'd0, 12'd2000, 32'h0000_0010, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd1, 12'd0, 32'h0000_0010, 1'b0});
      send_sample('{MODE_CAL, 4'd15, 12'd4095, 32'h0000_0010, 1'b1});
      wait_drained();
      // threshold at both ends, baseline snaps to level, downward press, short
      write_reg(hbed_pkg::REG_LONG_PRESS_MS, 65535);
      write_reg(hbed_pkg::REG_ADAPT_RATE, 65536);
      write_reg(hbed_pkg::REG_THRESHOLD, 4095);
      send_sample('{MODE_SAMPLE, 4'd2, 12'd4095, 32'h0000_0020, 1'b0});
      wait_drained();
      write_reg(hbed_pkg::REG_THRESHOLD, 0);
      send_sample('{MODE_SAMPLE, 4'd2, 12'd4095, 32'h0000_0021, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd2, 12'd0, 32'h0000_0022, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd2, 12'd0, 32'h0000_0030, 1'b1});
      send_sample('{MODE_SAMPLE, 4'd2, 12'd4095, 32'h0000_0040, 1'b0});
      wait_drained();
      // long reached with long events off: release must not report short
      write_reg(hbed_pkg::REG_EVENT_ENABLE, 5'h17);
      write_reg(hbed_pkg::REG_LONG_PRESS_MS, 1);
      write_reg(hbed_pkg::REG_COMBO_MASK, 0);
      write_reg(hbed_pkg::REG_THRESHOLD, 50);
      write_reg(hbed_pkg::REG_ADAPT_RATE, 32'h1FFFF);
      write_reg(hbed_pkg::REG_FILTER_ALPHA, 65536);
      send_sample('{MODE_CAL, 4'd3, 12'd100, 32'h0000_0100, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd3, 12'd4095, 32'h0000_0100, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd3, 12'd4095, 32'h0000_0200, 1'b0});
      send_sample('{MODE_SAMPLE, 4'd3, 12'd100, 32'h0000_0200, 1'b1});
      wait_drained();
      // zero filter weight freezes the level; full mask, events off
      write_reg(hbed_pkg::REG_FILTER_ALPHA, 0);
      write_reg(hbed_pkg::REG_COMBO_MASK, 32'hFFFF);
      write_reg(hbed_pkg::REG_EVENT_ENABLE, 0);
      send_sample('{MODE_SAMPLE, 4'd3, 12'd4095, 32'h0000_0300, 1'b1});
      wait_drained();
   endtask

   task automatic test_random_scans(input int n_items, input int gap, input int stall);
      wait_drained();
      shuffle_config();
      gap_pct   = gap;
      stall_pct = stall;
      calibrate_all();
      send_scans(n_items);
      wait_drained();
   endtask

   // output held off while input keeps coming, then a full drain mid-stream
   task automatic test_output_holdoff();
      wait_drained();
      shuffle_config();
      gap_pct   = 0;
      stall_pct = 0;
      holdoff_go <= ~holdoff_go;
      send_scans(40);
      wait_drained();
      gap_pct   = 30;
      stall_pct = 30;
      send_scans(30);
      holdoff_go <= ~holdoff_go;
      send_scans(30);
      wait_drained();
   endtask

   initial begin
      clear_detector_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_random_scans(300, 0, 0);
      test_random_scans(300, 77, 0);
      test_random_scans(300, 0, 77);
      test_random_scans(300, 11, 11);
      test_output_holdoff();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bad_reports == 0 && pending_reports.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: hall_button_event_detector.f
rtl/hbed_pkg.sv
rtl/hbed_csr.sv
rtl/hbed_ctrl.sv
rtl/hbed_dp.sv
rtl/hall_button_event_detector.sv
bench/tb_hall_button_event_detector.sv
